// ----- rtl/awd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// awd_pkg
// Shared widths, register indexes and stream layouts of the activity wake
// detector.
// ----------------------------------------------------------------------------
package awd_pkg;

  localparam int unsigned GRACE_W     = 16;
  localparam int unsigned DZ_W        = 12;
  localparam int unsigned DZ_SQ_W     = 2 * DZ_W;
  localparam int unsigned ELAPSED_W   = 32;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned KEY_WORD_W  = 64;
  localparam int unsigned KEY_TOTAL   = 256;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned IN_BITS     = ELAPSED_W + 1 + 2 * POS_W + KEY_TOTAL;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam int unsigned DIST_W      = 2 * POS_W + 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_GRACE_MS     = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_ZONE_PX = 1'b1;

  localparam logic [GRACE_W-1:0]    GRACE_RESET      = 16'd1000;
  localparam logic [DZ_SQ_W-1:0]    DZ_SQ_RESET      = 24'd100;

  typedef struct packed {
    logic [KEY_TOTAL-1:0]   keys;
    logic [POS_W-1:0]       cursor_y;
    logic [POS_W-1:0]       cursor_x;
    logic                   cursor_ok;
    logic [ELAPSED_W-1:0]   elapsed_ms;
  } sample_t;

endpackage
`default_nettype wire

// ----- rtl/activity_wake_detector_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// activity_wake_detector_top
// Flags new user activity from cursor and keyboard samples after a grace time.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the slave stream is one sample: elapsed time, cursor validity
// and position, and 256 key-down bits. For every item the master stream
// returns one item whose only bit says whether the sample shows new activity.
// The first sample at or after the grace time arms the block and yields zero.
// The sample is captured in an input register; combinational logic (two 16-bit
// squarers, a 33-bit compare and a key priority mask) updates the state and
// loads the result register, from which the result item is sent. One sample is
// taken in every cycle while the receiver takes the results.
// When the receiver stalls, the result register holds its item and the input
// register still takes one more sample; after that tready falls until the
// result is taken. Reset clears the armed flag, the cursor reference flag,
// both stream stages and sets the registers to a grace time of 1000 ms and a
// dead zone of 10 pixels. The held-key record is written when the block arms.
// Configuration writes are taken in any cycle but belong to idle periods.
// ----------------------------------------------------------------------------
module activity_wake_detector_top #(
  parameter int unsigned NUM_KEYS = 256
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // elapsed_ms[31:0], cursor_ok[32], cursor_x[48:33], cursor_y[64:49],
  // keys_lo[128:65], keys_mid_lo[192:129], keys_mid_hi[256:193],
  // keys_hi[320:257], zero fill above
  input  wire  [awd_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  wire                                 s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // wake[0], zero fill above
  output logic [awd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  wire                                 m_axis_tready_i,
  input  wire                                 cfg_we_i,
  input  wire  [awd_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  wire  [awd_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import awd_pkg::*;

  sample_t                  in_sample;
  logic                     in_valid_q;
  logic [ELAPSED_W-1:0]     elapsed_q;
  logic                     cursor_ok_q;
  logic [POS_W-1:0]         cursor_x_q;
  logic [POS_W-1:0]         cursor_y_q;
  logic [NUM_KEYS-1:0]      keys_q;

  logic                     out_valid_q;
  logic                     out_valid_d;
  logic                     wake_q;
  logic                     wake_d;

  logic [GRACE_W-1:0]       grace_q;
  logic [DZ_SQ_W-1:0]       dz_sq_q;

  logic                     armed_q;
  logic                     armed_d;
  logic                     ref_valid_q;
  logic                     ref_valid_d;
  logic [POS_W-1:0]         ref_x_q;
  logic [POS_W-1:0]         ref_x_d;
  logic [POS_W-1:0]         ref_y_q;
  logic [POS_W-1:0]         ref_y_d;
  logic [NUM_KEYS-1:0]      held_q;
  logic [NUM_KEYS-1:0]      held_d;

  logic                     in_take;
  logic                     proc;
  logic                     grace_done;
  logic signed [POS_W:0]    dx;
  logic signed [POS_W:0]    dy;
  logic [POS_W:0]           dx_abs;
  logic [POS_W:0]           dy_abs;
  logic [2*POS_W-1:0]       sq_x;
  logic [2*POS_W-1:0]       sq_y;
  logic [DIST_W-1:0]        dist_sq;
  logic                     cursor_wake;
  logic [NUM_KEYS-1:0]      new_press;
  logic [NUM_KEYS-1:0]      below_press;

  assign in_sample       = sample_t'(s_axis_tdata_i[IN_BITS-1:0]);
  assign proc            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      elapsed_q   <= in_sample.elapsed_ms;
      cursor_ok_q <= in_sample.cursor_ok;
      cursor_x_q  <= in_sample.cursor_x;
      cursor_y_q  <= in_sample.cursor_y;
      keys_q      <= in_sample.keys[NUM_KEYS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grace_q <= GRACE_RESET;
      dz_sq_q <= DZ_SQ_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_GRACE_MS: begin
          grace_q <= cfg_data_i[GRACE_W-1:0];
        end
        CFG_DEAD_ZONE_PX: begin
          dz_sq_q <= DZ_SQ_W'(cfg_data_i[DZ_W-1:0]) * DZ_SQ_W'(cfg_data_i[DZ_W-1:0]);
        end
        default: begin
          grace_q <= grace_q;
        end
      endcase
    end
  end

  assign grace_done = elapsed_q >= {{(ELAPSED_W-GRACE_W){1'b0}}, grace_q};

  assign dx     = $signed({cursor_x_q[POS_W-1], cursor_x_q})
                - $signed({ref_x_q[POS_W-1], ref_x_q});
  assign dy     = $signed({cursor_y_q[POS_W-1], cursor_y_q})
                - $signed({ref_y_q[POS_W-1], ref_y_q});
  assign dx_abs = dx[POS_W] ? (~dx + 1'b1) : dx;
  assign dy_abs = dy[POS_W] ? (~dy + 1'b1) : dy;
  assign sq_x   = dx_abs[POS_W-1:0] * dx_abs[POS_W-1:0];
  assign sq_y   = dy_abs[POS_W-1:0] * dy_abs[POS_W-1:0];
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};

  assign cursor_wake = cursor_ok_q && ref_valid_q
                    && (dist_sq > {{(DIST_W-DZ_SQ_W){1'b0}}, dz_sq_q});

  // Keys below the lowest new press get their releases applied (all keys if none).
  assign new_press   = keys_q & ~held_q;
  assign below_press = (new_press - 1'b1) & ~new_press;

  always_comb begin
    armed_d     = armed_q;
    ref_valid_d = ref_valid_q;
    ref_x_d     = ref_x_q;
    ref_y_d     = ref_y_q;
    held_d      = held_q;
    wake_d      = wake_q;
    if (proc) begin
      wake_d = 1'b0;
      if (grace_done) begin
        if (!armed_q) begin
          armed_d = 1'b1;
          held_d  = keys_q;
          if (cursor_ok_q) begin
            ref_valid_d = 1'b1;
            ref_x_d     = cursor_x_q;
            ref_y_d     = cursor_y_q;
          end
        end else begin
          if (cursor_ok_q && !ref_valid_q) begin
            ref_valid_d = 1'b1;
            ref_x_d     = cursor_x_q;
            ref_y_d     = cursor_y_q;
          end
          if (cursor_wake) begin
            wake_d = 1'b1;
          end else begin
            wake_d = |new_press;
            held_d = held_q & (keys_q | ~below_press);
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      ref_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      armed_q     <= armed_d;
      ref_valid_q <= ref_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ref_x_q <= ref_x_d;
    ref_y_q <= ref_y_d;
    held_q  <= held_d;
    wake_q  <= wake_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_TDATA_W-1){1'b0}}, wake_q};

  a_armed_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |=> armed_q)
    else $error("armed flag dropped");

  a_ref_needs_arm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ref_valid_q |-> armed_q)
    else $error("cursor reference valid while not armed");

  a_wake_only_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && wake_d) |-> armed_q)
    else $error("wake reported before arming");

  a_held_only_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && armed_q) |=> ((held_q & ~$past(held_q)) == '0))
    else $error("held key record gained a key after arming");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled with an empty result register");

endmodule
`default_nettype wire

// ----- tb/awd_wake_sb_pkg.sv -----
// ----------------------------------------------------------------------------
// awd_wake_sb_pkg
// Scoreboard for the activity wake detector. It keeps its own copy of the
// registers, the armed flag, the cursor reference and the held-key record,
// works out the wake bit of every accepted sample, and checks the result
// items against those bits in order.
// ----------------------------------------------------------------------------
package awd_wake_sb_pkg;

  import awd_pkg::*;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = 12'd10;
  localparam int unsigned     MAX_REPORTS     = 10;

  class wake_scoreboard;

    logic [GRACE_W-1:0]      grace_limit;
    logic [DZ_W-1:0]         dead_zone;
    bit                      armed;
    bit                      cursor_ref_ok;
    logic signed [POS_W-1:0] cursor_ref_x;
    logic signed [POS_W-1:0] cursor_ref_y;
    logic [KEY_TOTAL-1:0]    held_keys;
    bit                      wake_expected[$];
    int unsigned             n_samples;
    int unsigned             n_ignored;
    int unsigned             n_results;
    int unsigned             n_wakes;
    int unsigned             n_fail;

    function new();
      grace_limit   = GRACE_RESET;
      dead_zone     = DEAD_ZONE_RESET;
      armed         = 1'b0;
      cursor_ref_ok = 1'b0;
      cursor_ref_x  = '0;
      cursor_ref_y  = '0;
      held_keys     = '0;
      n_samples     = 0;
      n_ignored     = 0;
      n_results     = 0;
      n_wakes       = 0;
      n_fail        = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_GRACE_MS:     grace_limit = data[GRACE_W-1:0];
        CFG_DEAD_ZONE_PX: dead_zone   = data[DZ_W-1:0];
        default: ;
      endcase
    endfunction

    function bit predict_wake(sample_t smp);
      int              dx;
      int              dy;
      longint unsigned ax;
      longint unsigned ay;
      longint unsigned dist_sq;
      longint unsigned zone_sq;
      int              i;
      if (smp.elapsed_ms < {16'd0, grace_limit}) begin
        n_ignored++;
        return 1'b0;
      end
      if (!armed) begin
        if (smp.cursor_ok) begin
          cursor_ref_x  = smp.cursor_x;
          cursor_ref_y  = smp.cursor_y;
          cursor_ref_ok = 1'b1;
        end
        held_keys = smp.keys;
        armed     = 1'b1;
        return 1'b0;
      end
      if (smp.cursor_ok) begin
        if (!cursor_ref_ok) begin
          cursor_ref_x  = smp.cursor_x;
          cursor_ref_y  = smp.cursor_y;
          cursor_ref_ok = 1'b1;
        end else begin
          dx      = int'($signed(smp.cursor_x)) - int'(cursor_ref_x);
          dy      = int'($signed(smp.cursor_y)) - int'(cursor_ref_y);
          ax      = (dx < 0) ? -dx : dx;
          ay      = (dy < 0) ? -dy : dy;
          dist_sq = ax * ax + ay * ay;
          zone_sq = longint'(dead_zone) * longint'(dead_zone);
          if (dist_sq > zone_sq) begin
            return 1'b1;
          end
        end
      end
      for (i = 0; i < KEY_TOTAL; i++) begin
        if (smp.keys[i]) begin
          if (!held_keys[i]) begin
            return 1'b1;
          end
        end else begin
          held_keys[i] = 1'b0;
        end
      end
      return 1'b0;
    endfunction

    function void note_failure(string msg);
      n_fail++;
      if (n_fail <= MAX_REPORTS) begin
        $display("MISMATCH: %s", msg);
      end
    endfunction

    function void note_sample(sample_t smp);
      n_samples++;
      wake_expected.push_back(predict_wake(smp));
    endfunction

    function void check_wake(logic [OUT_TDATA_W-1:0] tdata);
      bit want;
      n_results++;
      if (tdata[0] === 1'b1) begin
        n_wakes++;
      end
      if (wake_expected.size() == 0) begin
        note_failure($sformatf("result %0d arrived with no sample waiting, wake=%b",
                               n_results, tdata[0]));
      end else begin
        want = wake_expected.pop_front();
        if (tdata[0] !== want) begin
          note_failure($sformatf("result %0d: wake expected %b, got %b",
                                 n_results, want, tdata[0]));
        end
      end
    endfunction

    function int unsigned pending();
      return wake_expected.size();
    endfunction

    function void close();
      if (wake_expected.size() != 0) begin
        note_failure($sformatf("%0d wake results never arrived", wake_expected.size()));
      end
    endfunction

  endclass

endpackage

// ----- tb/activity_wake_detector_top_test.sv -----
// ----------------------------------------------------------------------------
// activity_wake_detector_top_test
// Streams cursor and keyboard samples into the activity wake detector and
// checks every wake result against a scoreboard. A directed sequence covers
// the grace time, arming, the first valid cursor, the dead zone edge and the
// key scan order; random phases then vary both registers, including their
// extremes, some with random gaps on the sender or random stalls on the receiver.
// ----------------------------------------------------------------------------
module activity_wake_detector_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import awd_pkg::*;
  import awd_wake_sb_pkg::*;

  localparam int unsigned CLK_PERIOD      = 8;
  localparam int unsigned RESET_CYCLES    = 8;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned ITEMS_PER_PHASE = 80;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i  = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i      = '0;

  wake_scoreboard          sb;
  logic [KEY_TOTAL-1:0]    key_state = '0;
  bit                      tx_idling = 1'b1;
  bit                      rx_idling = 1'b1;
  int unsigned             rx_stall_left = 0;
  int unsigned             rx_pick;
  int unsigned             quiet_cycles = 0;
  int unsigned             settings_run = 1;

  activity_wake_detector_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rx_stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      rx_stall_left = rx_stall_left - 1;
    end else if (!rx_idling) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 80) begin
        m_axis_tready_i <= 1'b1;
      end else if (rx_pick < 96) begin
        m_axis_tready_i <= 1'b0;
        rx_stall_left = $urandom_range(0, 2);
      end else begin
        m_axis_tready_i <= 1'b0;
        rx_stall_left = $urandom_range(5, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      sb.note_sample(sample_t'(s_axis_tdata_i[IN_BITS-1:0]));
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_wake(m_axis_tdata_o);
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (!tx_idling) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [KEY_TOTAL-1:0] random_keys();
    logic [KEY_TOTAL-1:0] w;
    int                   i;
    for (i = 0; i < KEY_TOTAL / 32; i++) begin
      w[i*32 +: 32] = $urandom();
    end
    return w;
  endfunction

  function automatic sample_t make_sample(logic [31:0] elapsed, bit ok, int x, int y,
                                          logic [KEY_TOTAL-1:0] keys);
    sample_t smp;
    smp.elapsed_ms = elapsed;
    smp.cursor_ok  = ok;
    smp.cursor_x   = 16'(x);
    smp.cursor_y   = 16'(y);
    smp.keys       = keys;
    return smp;
  endfunction

  function automatic sample_t random_sample();
    sample_t     smp;
    int unsigned pick;
    int unsigned idx;
    int          span;
    int          grace;
    grace = int'(sb.grace_limit);
    pick  = $urandom_range(0, 99);
    if (pick < 12 && grace != 0) begin
      smp.elapsed_ms = $urandom_range(0, grace - 1);
    end else if (pick < 20) begin
      smp.elapsed_ms = grace;
    end else begin
      smp.elapsed_ms = $urandom();
    end

    pick = $urandom_range(0, 99);
    smp.cursor_ok = (pick >= 10);
    if (pick < 10 || pick >= 80) begin
      smp.cursor_x = 16'($urandom());
      smp.cursor_y = 16'($urandom());
    end else if (pick < 70) begin
      span = int'(sb.dead_zone) + int'(sb.dead_zone) / 4 + 2;
      smp.cursor_x = 16'(int'(sb.cursor_ref_x) + int'($urandom_range(0, 2 * span)) - span);
      smp.cursor_y = 16'(int'(sb.cursor_ref_y) + int'($urandom_range(0, 2 * span)) - span);
    end else begin
      smp.cursor_x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      smp.cursor_y = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    end

    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      idx = $urandom_range(0, KEY_TOTAL - 1);
      key_state[idx] = ~key_state[idx];
      if (pick >= 40) begin
        idx = $urandom_range(0, KEY_TOTAL - 1);
        key_state[idx] = ~key_state[idx];
      end
    end else if (pick < 65) begin
      key_state = key_state;
    end else if (pick < 75) begin
      key_state = key_state & random_keys();
    end else if (pick < 85) begin
      key_state = random_keys();
    end else if (pick < 92) begin
      key_state = '0;
    end else begin
      key_state = '1;
    end
    smp.keys = key_state;
    return smp;
  endfunction

  task automatic send_sample(input sample_t smp);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, smp};
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [GRACE_W-1:0] grace, input logic [DZ_W-1:0] zone);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= CFG_GRACE_MS;
    cfg_data_i <= grace;
    @(posedge clk_i);
    cfg_addr_i <= CFG_DEAD_ZONE_PX;
    cfg_data_i <= CFG_DATA_W'(zone);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_reg(CFG_GRACE_MS, grace);
    sb.set_reg(CFG_DEAD_ZONE_PX, CFG_DATA_W'(zone));
    settings_run++;
  endtask

  task automatic run_directed();
    logic [KEY_TOTAL-1:0] held;
    logic [KEY_TOTAL-1:0] k;
    held = '0;
    held[0]   = 1'b1;
    held[100] = 1'b1;
    held[255] = 1'b1;
    send_sample(make_sample(32'd0, 1'b1, 50, 60, '1));
    send_sample(make_sample(32'd999, 1'b1, -5, 7, random_keys()));
    send_sample(make_sample(32'd1000, 1'b0, 123, -321, held));
    send_sample(make_sample(32'd1001, 1'b1, -32768, -32768, held));
    send_sample(make_sample(32'd1002, 1'b1, -32762, -32760, held));
    k = held;
    k[50] = 1'b1;
    send_sample(make_sample(32'd1003, 1'b1, -32762, -32759, k));
    send_sample(make_sample(32'd1004, 1'b0, 32767, 32767, held));
    k = held;
    k[100] = 1'b0;
    send_sample(make_sample(32'd1005, 1'b1, -32768, -32768, k));
    send_sample(make_sample(32'd1006, 1'b1, -32768, -32768, held));
    k = '0;
    k[255] = 1'b1;
    send_sample(make_sample(32'd1007, 1'b1, -32768, -32768, k));
    k = '0;
    k[10] = 1'b1;
    send_sample(make_sample(32'd1008, 1'b1, -32768, -32768, k));
    k = '0;
    k[255] = 1'b1;
    send_sample(make_sample(32'd1009, 1'b1, -32768, -32768, k));
    send_sample(make_sample(32'd1010, 1'b1, -32768, -32768, '1));
    send_sample(make_sample(32'hffff_ffff, 1'b1, 32767, 32767, '1));
    send_sample(make_sample(32'd999, 1'b1, 32767, 32767, '0));
    send_sample(make_sample(32'd2000, 1'b1, -32768, -32768, '0));
    k = '0;
    k[0]   = 1'b1;
    k[255] = 1'b1;
    send_sample(make_sample(32'd2001, 1'b1, -32768, -32768, k));
    send_sample(make_sample(32'd2002, 1'b1, -32767, -32768, k));
  endtask

  initial begin
    int unsigned ph;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: begin
          load_config(16'd0, 12'd0);
          tx_idling = 1'b1;
          rx_idling = 1'b1;
        end
        1: begin
          load_config(16'hffff, 12'hfff);
          tx_idling = 1'b1;
          rx_idling = 1'b0;
        end
        2: begin
          load_config(16'($urandom()), 12'($urandom()));
          tx_idling = 1'b0;
          rx_idling = 1'b1;
        end
        3: begin
          load_config(GRACE_RESET, DEAD_ZONE_RESET);
          tx_idling = 1'b0;
          rx_idling = 1'b0;
        end
        default: begin
          load_config(16'($urandom_range(0, 2000)), 12'($urandom_range(0, 64)));
          tx_idling = 1'b1;
          rx_idling = 1'b1;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_sample(random_sample());
    end

    settle();
    sb.close();
    $display("Sent %0d samples (%0d inside the grace time) under %0d register settings;",
             sb.n_samples, sb.n_ignored, settings_run);
    $display("checked %0d results, %0d of them reporting wake.", sb.n_results, sb.n_wakes);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- activity_wake_detector_top.f -----
rtl/awd_pkg.sv
rtl/activity_wake_detector_top.sv
tb/awd_wake_sb_pkg.sv
tb/activity_wake_detector_top_test.sv
